@@ hdl/lz_token_stream_decompressor_unit_assert.svh @@
// assertion macros shared by the checker
`ifndef LZ_TOKEN_STREAM_DECOMPRESSOR_UNIT_ASSERT_SVH
`define LZ_TOKEN_STREAM_DECOMPRESSOR_UNIT_ASSERT_SVH

// implication checked on every clock edge outside reset
`define LZD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the cycle after the antecedent
`define LZD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/lzd_pkg.sv @@
package lzd_pkg;

  typedef enum logic [3:0] {
    PH_FMT, PH_HDR, PH_HDR_BAD, PH_RAW, PH_TOKEN, PH_LITEXT, PH_LIT,
    PH_MATEXT, PH_OFF0, PH_OFF1, PH_COPY
  } phase_e;

  typedef enum logic [2:0] {
    OC_OK        = 3'd0,
    OC_SHORT_HDR = 3'd1,
    OC_BAD_FMT   = 3'd2,
    OC_LEN_CAP   = 3'd3,
    OC_TRUNC     = 3'd4,
    OC_CAP_EXC   = 3'd5,
    OC_BAD_OFF   = 3'd6
  } outcome_e;

  localparam logic [7:0]  FMT_RAW   = 8'h00;
  localparam logic [7:0]  FMT_TOKEN = 8'h02;
  localparam logic [3:0]  NIB_EXT   = 4'hF;
  localparam logic [7:0]  BYTE_EXT  = 8'd255;
  localparam logic [31:0] MATCH_EXT = 32'd18;
  localparam logic [31:0] MATCH_MIN = 32'd3;

  // one result item
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_data;
    logic       copy_pending;
    logic       stream_done;
    logic [2:0] outcome;
  } result_t;

  // memory access from the decoder
  typedef struct packed {
    logic        wr_en;
    logic [15:0] wr_ptr;
    logic [7:0]  wr_data;
    logic        rd_en;
    logic [15:0] rd_ptr;
  } hist_req_t;

endpackage

@@ hdl/lzd_ram.sv @@
module lzd_ram #(
  parameter int Width = 8,
  parameter int Depth = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ hdl/lzd_decoder.sv @@
module lzd_decoder
  import lzd_pkg::*;
#(
  parameter int HistoryDepth = 8192
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic        cmd_i,
  input  logic [7:0]  byte_i,
  input  logic        last_i,
  input  logic [31:0] cap_i,
  input  logic [7:0]  hist_rdata_i,
  output hist_req_t   hist_o,
  output logic        res_valid_o,
  output result_t     res_o
);

  localparam int AW = $clog2(HistoryDepth);
  localparam logic [32:0] DEPTH33 = 33'(HistoryDepth);

  phase_e      phase_q, phase_d;
  logic [1:0]  hidx_q, hidx_d;
  logic        raw_q, raw_d;
  logic [31:0] dlen_q, dlen_d;
  logic [31:0] prod_q, prod_d;
  logic [31:0] lit_q, lit_d;
  logic [31:0] mat_q, mat_d;
  logic [7:0]  offlo_q, offlo_d;
  logic [15:0] dist_q, dist_d;
  logic        fin_q, fin_d;

  // copy byte in flight: the memory data arrives in the cycle after the tick
  logic        cp_q;
  logic [AW-1:0] cp_addr_q;
  logic        fwd_q;
  logic [7:0]  fwd_data_q;
  logic        fwd_d;
  result_t     res_q, res_d;
  logic        rv_q;

  logic        emit, done, bvalid, is_copy, is_raw_emit;
  logic [2:0]  oc;
  logic [32:0] sum33;
  logic [32:0] lit_sat, mat_sat;
  logic [31:0] prod_inc;
  logic [AW-1:0] wp, rp;
  logic [7:0]  obyte;

  // history write position of the next output byte, and the copy read position behind it
  assign wp       = prod_q[AW-1:0];
  assign rp       = wp - dist_q[AW-1:0];
  assign prod_inc = prod_q + 32'd1;

  always_comb begin
    phase_d = phase_q; hidx_d = hidx_q; raw_d = raw_q; dlen_d = dlen_q;
    prod_d = prod_q; lit_d = lit_q; mat_d = mat_q; offlo_d = offlo_q;
    dist_d = dist_q; fin_d = fin_q;
    emit = 1'b0; bvalid = 1'b0; done = 1'b0; oc = OC_OK;
    is_copy = 1'b0; is_raw_emit = 1'b0;
    sum33 = 33'd0; lit_sat = 33'd0; mat_sat = 33'd0;
    hist_o = '0;
    fwd_d = 1'b0;
    if (step_i) begin
      if (cmd_i) begin
        if (!fin_q && phase_q == PH_COPY) begin
          is_copy = 1'b1;
          emit = 1'b1;
          mat_d = mat_q - 32'd1;
          prod_d = prod_inc;
          hist_o.rd_en = 1'b1;
          hist_o.rd_ptr = 16'(rp);
          fwd_d = cp_q && (rp == cp_addr_q);
          if (prod_inc == dlen_q) begin
            done = 1'b1; oc = OC_OK;
          end else if (mat_d == 32'd0) begin
            phase_d = PH_TOKEN;
          end
          if (done) fin_d = 1'b1;
        end
      end else if (fin_q) begin
        if (last_i) begin
          fin_d = 1'b0; phase_d = PH_FMT; hidx_d = 2'd0;
        end
      end else begin
        case (phase_q)
          PH_FMT: begin
            hidx_d = 2'd0; dlen_d = 32'd0;
            if (byte_i == FMT_RAW) begin
              raw_d = 1'b1; phase_d = PH_HDR;
            end else if (byte_i == FMT_TOKEN) begin
              raw_d = 1'b0; phase_d = PH_HDR;
            end else begin
              phase_d = PH_HDR_BAD;
            end
          end
          PH_HDR, PH_HDR_BAD: begin
            dlen_d = dlen_q | (32'(byte_i) << {hidx_q, 3'b000});
            hidx_d = hidx_q + 2'd1;
            if (hidx_q == 2'd3) begin
              prod_d = 32'd0;
              if (phase_q == PH_HDR_BAD) begin
                done = 1'b1; oc = OC_BAD_FMT;
              end else if (raw_q) begin
                if (dlen_d == 32'd0) done = 1'b1;
                else phase_d = PH_RAW;
              end else if (dlen_d > cap_i) begin
                done = 1'b1; oc = OC_LEN_CAP;
              end else if (dlen_d == 32'd0) begin
                done = 1'b1;
              end else begin
                phase_d = PH_TOKEN;
              end
            end
          end
          PH_RAW: begin
            if (prod_q < cap_i) begin
              bvalid = 1'b1; is_raw_emit = 1'b1;
            end
            prod_d = prod_inc;
            if (prod_inc == dlen_q) done = 1'b1;
          end
          PH_TOKEN: begin
            lit_d = 32'(byte_i[7:4]);
            mat_d = 32'(byte_i[3:0]) + MATCH_MIN;
            if (byte_i[7:4] == NIB_EXT) begin
              phase_d = PH_LITEXT;
            end else begin
              sum33 = {1'b0, prod_q} + 33'(byte_i[7:4]);
              if (sum33 > {1'b0, cap_i}) begin
                done = 1'b1; oc = OC_CAP_EXC;
              end else if (byte_i[7:4] == 4'd0) begin
                phase_d = (mat_d == MATCH_EXT) ? PH_MATEXT : PH_OFF0;
              end else begin
                phase_d = PH_LIT;
              end
            end
          end
          PH_LITEXT: begin
            lit_sat = {1'b0, lit_q} + 33'(byte_i);
            lit_d = lit_sat[32] ? 32'hFFFF_FFFF : lit_sat[31:0];
            if (byte_i != BYTE_EXT) begin
              sum33 = {1'b0, prod_q} + {1'b0, lit_d};
              if (sum33 > {1'b0, cap_i}) begin
                done = 1'b1; oc = OC_CAP_EXC;
              end else if (lit_d == 32'd0) begin
                phase_d = (mat_q == MATCH_EXT) ? PH_MATEXT : PH_OFF0;
              end else begin
                phase_d = PH_LIT;
              end
            end
          end
          PH_LIT: begin
            lit_d = lit_q - 32'd1;
            emit = 1'b1;
            prod_d = prod_inc;
            if (prod_inc == dlen_q) begin
              done = 1'b1;
            end else if (lit_d == 32'd0) begin
              phase_d = (mat_q == MATCH_EXT) ? PH_MATEXT : PH_OFF0;
            end
          end
          PH_MATEXT: begin
            mat_sat = {1'b0, mat_q} + 33'(byte_i);
            mat_d = mat_sat[32] ? 32'hFFFF_FFFF : mat_sat[31:0];
            if (byte_i != BYTE_EXT) phase_d = PH_OFF0;
          end
          PH_OFF0: begin
            offlo_d = byte_i; phase_d = PH_OFF1;
          end
          PH_OFF1: begin
            dist_d = {byte_i, offlo_q};
            sum33 = {1'b0, prod_q} + {1'b0, mat_q};
            if (dist_d == 16'd0) begin
              phase_d = PH_TOKEN;
            end else if (32'(dist_d) > prod_q || 33'(dist_d) > DEPTH33) begin
              done = 1'b1; oc = OC_BAD_OFF;
            end else if (sum33 > {1'b0, cap_i}) begin
              done = 1'b1; oc = OC_CAP_EXC;
            end else begin
              phase_d = PH_COPY;
            end
          end
          default: ;
        endcase
        if (!done && last_i) begin
          done = 1'b1;
          oc = (phase_d == PH_FMT || phase_d == PH_HDR || phase_d == PH_HDR_BAD)
               ? OC_SHORT_HDR : OC_TRUNC;
        end
        if (done) begin
          if (last_i) begin
            fin_d = 1'b0; phase_d = PH_FMT; hidx_d = 2'd0;
          end else begin
            fin_d = 1'b1;
          end
        end
      end
      if (emit) bvalid = 1'b1;
      // literals go straight into the history
      if (emit && !is_copy) begin
        hist_o.wr_en = 1'b1;
        hist_o.wr_ptr = 16'(wp);
        hist_o.wr_data = byte_i;
      end
    end
    // a copy byte is written in the cycle after its tick, once its data is out;
    // a literal never follows a tick directly, so the port is free then
    if (cp_q) begin
      hist_o.wr_en = 1'b1;
      hist_o.wr_ptr = 16'(cp_addr_q);
      hist_o.wr_data = obyte;
    end
    res_d.byte_valid   = bvalid;
    res_d.out_data     = (bvalid && !is_copy) ? byte_i : 8'd0;
    res_d.copy_pending = !fin_d && phase_d == PH_COPY;
    res_d.stream_done  = done;
    res_d.outcome      = done ? oc : OC_OK;
    if (is_raw_emit) res_d.out_data = byte_i;
  end

  // copy bytes are written in the cycle their read data returns, from the memory or the bypass
  always_comb begin
    obyte = fwd_q ? fwd_data_q : hist_rdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FMT; hidx_q <= '0; raw_q <= 1'b0; dlen_q <= '0;
      prod_q <= '0; lit_q <= '0; mat_q <= '0; offlo_q <= '0; dist_q <= '0;
      fin_q <= 1'b0; rv_q <= 1'b0; cp_q <= 1'b0; fwd_q <= 1'b0;
    end else begin
      phase_q <= phase_d; hidx_q <= hidx_d; raw_q <= raw_d; dlen_q <= dlen_d;
      prod_q <= prod_d; lit_q <= lit_d; mat_q <= mat_d; offlo_q <= offlo_d;
      dist_q <= dist_d; fin_q <= fin_d;
      rv_q <= step_i;
      cp_q <= step_i && is_copy;
      fwd_q <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    cp_addr_q <= wp;
    // copy byte being written now, bypassed to a tick that reads it at once
    if (cp_q) fwd_data_q <= obyte;
  end

  assign res_valid_o = rv_q;
  always_comb begin
    res_o = res_q;
    if (cp_q) res_o.out_data = obyte;
  end

endmodule

@@ hdl/lz_token_stream_decompressor_unit.sv @@
// lz token stream decompressor: takes one compressed byte (tuser 0) or one copy
// tick (tuser 1) per transfer and returns exactly one result transfer for each.
// a stream is a format byte, a 32-bit little-endian length and then either raw
// payload (format 0) or lz4-style tokens (format 2). match bytes are read from
// a history ram of HISTORY_DEPTH bytes, one per tick; overlapping copies work.
// throughput is one transfer per cycle while the output queue has room; each
// result is registered, then queued. the history ram is not cleared after
// reset; offsets are checked so only bytes of the current stream are read.
// output_capacity must be written only while the block is idle (not enforced).
module lz_token_stream_decompressor_unit
  import lzd_pkg::*;
#(
  parameter int HISTORY_DEPTH = 8192
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,    // output_capacity
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // data_byte
  input  logic        s_axis_tuser,  // command
  input  logic        s_axis_tlast,  // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // byte_valid, out_data, copy_pending, outcome, pad
  output logic        m_axis_tlast   // stream_done
);

  localparam int AW = $clog2(HISTORY_DEPTH);

  logic [31:0] cap_q;
  hist_req_t   hist;
  logic [7:0]  hist_rdata;
  logic        step, res_valid;
  result_t     res;

  // skid: two entry output queue catches the in-flight results while the sink stalls
  result_t     buf_q [2];
  logic [1:0]  cnt_q, cnt_d;
  logic        rd_ptr_q, wr_ptr_q;
  logic [1:0]  inflight_q;
  logic        pop;

  // accept only when in-flight results are sure to find a slot
  assign s_axis_tready = (2'(cnt_q) + inflight_q) < 2'd2 ||
                         ({1'b0, cnt_q} + {1'b0, inflight_q} == 3'd2 && pop);
  assign step = s_axis_tvalid && s_axis_tready;
  assign pop  = m_axis_tvalid && m_axis_tready;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cap_q <= 32'hFFFF_FFFF;
    else if (cfg_valid_i) cap_q <= cfg_data_i;
  end

  lzd_ram #(.Width(8), .Depth(HISTORY_DEPTH)) u_hist (
    .clk_i  (clk_i),
    .we_i   (hist.wr_en),
    .waddr_i(hist.wr_ptr[AW-1:0]),
    .wdata_i(hist.wr_data),
    .re_i   (hist.rd_en),
    .raddr_i(hist.rd_ptr[AW-1:0]),
    .rdata_o(hist_rdata)
  );

  lzd_decoder #(.HistoryDepth(HISTORY_DEPTH)) u_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .cmd_i       (s_axis_tuser),
    .byte_i      (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .cap_i       (cap_q),
    .hist_rdata_i(hist_rdata),
    .hist_o      (hist),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    cnt_d = cnt_q + {1'b0, res_valid} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; rd_ptr_q <= 1'b0; wr_ptr_q <= 1'b0; inflight_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      if (res_valid) wr_ptr_q <= ~wr_ptr_q;
      inflight_q <= {1'b0, step};
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) buf_q[wr_ptr_q] <= res;
  end

  assign m_axis_tvalid = cnt_q != 2'd0;
  assign m_axis_tdata  = {2'b00, buf_q[rd_ptr_q].outcome, buf_q[rd_ptr_q].copy_pending,
                          buf_q[rd_ptr_q].out_data, buf_q[rd_ptr_q].byte_valid};
  assign m_axis_tlast  = buf_q[rd_ptr_q].stream_done;

endmodule

@@ hdl/lzd_checker.sv @@
`include "lz_token_stream_decompressor_unit_assert.svh"

module lzd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  `LZD_ASSERT_IMPL(a_no_data_without_valid, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[8:1] == 8'd0,
    "data byte set without byte_valid")
  `LZD_ASSERT_IMPL(a_outcome_only_on_done, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tlast, m_axis_tdata[12:10] == 3'd0,
    "outcome set on a non-final result")
  `LZD_ASSERT_IMPL(a_outcome_range, clk_i, rst_ni,
    m_axis_tvalid, m_axis_tdata[12:10] != 3'd7, "outcome code out of range")
  `LZD_ASSERT_NEXT(a_out_holds, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata),
    "stalled result changed")

endmodule

bind lz_token_stream_decompressor_unit lzd_checker u_lzd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);

@@ tb/sv/lzd_stream_checker.sv @@
`timescale 1ns / 1ps

module lzd_stream_checker
  import lzd_pkg::*;
#(
  parameter int HISTORY_DEPTH = 8192
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  output int          fail_count,
  output int          results_due,
  output int          results_seen,
  output int          streams_ended,
  output int          copies_seen
);

  logic [31:0] capacity;
  phase_e      dec_phase;
  logic [2:0]  hdr_idx;
  logic        raw_mode;
  logic [31:0] decl_len;
  logic [31:0] produced;
  logic [31:0] lit_left;
  logic [31:0] match_left;
  logic [7:0]  off_lo;
  logic [15:0] distance;
  logic        discarding;
  logic [7:0]  history [HISTORY_DEPTH];

  result_t     pending_results [$];
  result_t     nxt;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    fail_count++;
  endtask

  function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [7:0] b);
    logic [32:0] s;
    s = {1'b0, a} + b;
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  task automatic close_stream(input outcome_e code);
    nxt.stream_done = 1'b1;
    nxt.outcome     = code;
  endtask

  task automatic emit_byte(input logic [7:0] b);
    history[produced % HISTORY_DEPTH] = b;
    produced++;
    nxt.byte_valid = 1'b1;
    nxt.out_data   = b;
    if (produced == decl_len) close_stream(OC_OK);
  endtask

  task automatic literals_done();
    dec_phase = (match_left == MATCH_EXT) ? PH_MATEXT : PH_OFF0;
  endtask

  task automatic literal_count_known();
    if ({1'b0, produced} + lit_left > {1'b0, capacity}) close_stream(OC_CAP_EXC);
    else if (lit_left == 0) literals_done();
    else dec_phase = PH_LIT;
  endtask

  task automatic header_complete();
    produced = 0;
    if (dec_phase == PH_HDR_BAD) close_stream(OC_BAD_FMT);
    else if (raw_mode) begin
      if (decl_len == 0) close_stream(OC_OK);
      else dec_phase = PH_RAW;
    end else if (decl_len > capacity) close_stream(OC_LEN_CAP);
    else if (decl_len == 0) close_stream(OC_OK);
    else dec_phase = PH_TOKEN;
  endtask

  task automatic decode_byte(input logic [7:0] b);
    case (dec_phase)
      PH_FMT: begin
        hdr_idx  = 0;
        decl_len = 0;
        if (b == FMT_RAW) begin
          raw_mode  = 1'b1;
          dec_phase = PH_HDR;
        end else if (b == FMT_TOKEN) begin
          raw_mode  = 1'b0;
          dec_phase = PH_HDR;
        end else dec_phase = PH_HDR_BAD;
      end
      PH_HDR, PH_HDR_BAD: begin
        decl_len = decl_len | (32'(b) << (hdr_idx[1:0] * 8));
        hdr_idx++;
        if (hdr_idx >= 4) header_complete();
      end
      PH_RAW: begin
        if (produced < capacity) begin
          nxt.byte_valid = 1'b1;
          nxt.out_data   = b;
        end
        produced++;
        if (produced == decl_len) close_stream(OC_OK);
      end
      PH_TOKEN: begin
        lit_left   = 32'(b[7:4]);
        match_left = 32'(b[3:0]) + MATCH_MIN;
        if (b[7:4] == NIB_EXT) dec_phase = PH_LITEXT;
        else literal_count_known();
      end
      PH_LITEXT: begin
        lit_left = sat_sum(lit_left, b);
        if (b != BYTE_EXT) literal_count_known();
      end
      PH_LIT: begin
        lit_left--;
        emit_byte(b);
        if (!nxt.stream_done && lit_left == 0) literals_done();
      end
      PH_MATEXT: begin
        match_left = sat_sum(match_left, b);
        if (b != BYTE_EXT) dec_phase = PH_OFF0;
      end
      PH_OFF0: begin
        off_lo    = b;
        dec_phase = PH_OFF1;
      end
      PH_OFF1: begin
        distance = {b, off_lo};
        if (distance == 0) dec_phase = PH_TOKEN;
        else if (distance > produced || distance > HISTORY_DEPTH) close_stream(OC_BAD_OFF);
        else if ({1'b0, produced} + match_left > {1'b0, capacity}) close_stream(OC_CAP_EXC);
        else dec_phase = PH_COPY;
      end
      default: ;
    endcase
  endtask

  task automatic restart_stream();
    discarding = 1'b0;
    dec_phase  = PH_FMT;
    hdr_idx    = 0;
  endtask

  task automatic predict(input logic tick, input logic [7:0] b, input logic last);
    int wp;
    int rp;
    nxt = '0;
    if (tick) begin
      if (!discarding && dec_phase == PH_COPY) begin
        wp = produced % HISTORY_DEPTH;
        rp = (wp + HISTORY_DEPTH - distance) % HISTORY_DEPTH;
        match_left--;
        copies_seen++;
        emit_byte(history[rp]);
        if (!nxt.stream_done && match_left == 0) dec_phase = PH_TOKEN;
        if (nxt.stream_done) discarding = 1'b1;
      end
    end else if (discarding) begin
      if (last) restart_stream();
    end else begin
      decode_byte(b);
      if (!nxt.stream_done && last) begin
        if (dec_phase inside {PH_FMT, PH_HDR, PH_HDR_BAD}) close_stream(OC_SHORT_HDR);
        else close_stream(OC_TRUNC);
      end
      if (nxt.stream_done) begin
        if (last) restart_stream();
        else discarding = 1'b1;
      end
    end
    nxt.copy_pending = !discarding && dec_phase == PH_COPY;
    if (nxt.stream_done) streams_ended++;
    pending_results.push_back(nxt);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      capacity      = 32'hFFFF_FFFF;
      dec_phase     = PH_FMT;
      hdr_idx       = 0;
      raw_mode      = 0;
      decl_len      = 0;
      produced      = 0;
      lit_left      = 0;
      match_left    = 0;
      off_lo        = 0;
      distance      = 0;
      discarding    = 0;
      fail_count    = 0;
      results_seen  = 0;
      streams_ended = 0;
      copies_seen   = 0;
      pending_results.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) capacity = cfg_data_i;
      // compare before predicting: a result never leaves in the cycle its input arrives
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $display("unexpected result transfer at %0t", $time);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (m_axis_tdata[0] !== want.byte_valid)
            report("byte_valid", m_axis_tdata[0], want.byte_valid);
          if (m_axis_tdata[8:1] !== want.out_data)
            report("out_data", m_axis_tdata[8:1], want.out_data);
          if (m_axis_tdata[9] !== want.copy_pending)
            report("copy_pending", m_axis_tdata[9], want.copy_pending);
          if (m_axis_tlast !== want.stream_done)
            report("stream_done", m_axis_tlast, want.stream_done);
          if (m_axis_tdata[12:10] !== want.outcome)
            report("outcome", m_axis_tdata[12:10], want.outcome);
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict(s_axis_tuser, s_axis_tdata, s_axis_tlast);
    end
    results_due = pending_results.size();
  end

endmodule

@@ tb/sv/lz_token_stream_decompressor_unit_tb.sv @@
`timescale 1ns / 1ps

module lz_token_stream_decompressor_unit_tb;
  import lzd_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  // one input transfer: copy tick or compressed byte
  typedef struct packed {
    logic       tick;
    logic [7:0] data;
    logic       last;
  } in_item_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // data_byte
  logic        s_axis_tuser;   // command
  logic        s_axis_tlast;   // last
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // byte_valid, out_data, copy_pending, outcome, pad
  logic        m_axis_tlast;   // stream_done

  int       fail_count;
  int       results_due;
  int       results_seen;
  int       streams_ended;
  int       copies_seen;
  in_item_t byte_stream [$];
  int       bytes_sent;
  logic     hold_off;
  int       idle_cycles = 0;

  lz_token_stream_decompressor_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // predicts every result and compares it, counts failures for the verdict
  lzd_stream_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count    (fail_count),
    .results_due   (results_due),
    .results_seen  (results_seen),
    .streams_ended (streams_ended),
    .copies_seen   (copies_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic push_byte(input logic [7:0] b, input logic last = 1'b0);
    byte_stream.push_back('{tick: 1'b0, data: b, last: last});
  endtask

  task automatic push_ticks(input int n);
    repeat (n) byte_stream.push_back('{tick: 1'b1, data: 8'($urandom), last: 1'(
      $urandom_range(0, 1))});
  endtask

  task automatic push_header(input logic [7:0] fmt, input logic [31:0] len);
    push_byte(fmt);
    for (int i = 0; i < 4; i++) push_byte(len[i*8 +: 8]);
  endtask

  // mostly well-formed token stream with random content; the declared length is
  // sometimes short or long so early ends and truncation are hit too
  task automatic gen_token_stream();
    in_item_t body [$];
    int       out_len;
    int       lit;
    int       mlen;
    int       offs;
    int       decl;
    out_len = 0;
    repeat ($urandom_range(1, 4)) begin
      lit  = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 14);
      mlen = ($urandom_range(0, 4) == 0) ? $urandom_range(18, 40) : $urandom_range(3, 17);
      body.push_back('{1'b0, {4'(lit > 15 ? 15 : lit), 4'(mlen - 3 > 15 ? 15 : mlen - 3)}, 1'b0});
      if (lit >= 15) body.push_back('{1'b0, 8'(lit - 15), 1'b0});
      repeat (lit) body.push_back('{1'b0, 8'($urandom), 1'b0});
      out_len += lit;
      if (mlen >= 18) body.push_back('{1'b0, 8'(mlen - 18), 1'b0});
      // offset zero skips the match; a few reach past what was produced
      if (out_len == 0 || $urandom_range(0, 9) == 0) offs = 0;
      else if ($urandom_range(0, 19) == 0) offs = out_len + $urandom_range(1, 3);
      else offs = $urandom_range(1, out_len);
      body.push_back('{1'b0, 8'(offs), 1'b0});
      body.push_back('{1'b0, 8'(offs >> 8), 1'b0});
      if (offs != 0) begin
        repeat (mlen) body.push_back('{1'b1, 8'($urandom), 1'b0});
        out_len += mlen;
      end
    end
    case ($urandom_range(0, 9))
      0, 1:    decl = out_len + $urandom_range(1, 5);
      2:       decl = (out_len > 0) ? $urandom_range(1, out_len) : 0;
      default: decl = out_len;
    endcase
    push_header(FMT_TOKEN, decl);
    foreach (body[i]) byte_stream.push_back(body[i]);
    // closes the stream; a tick never ends a discard
    push_byte(8'($urandom), 1'b1);
  endtask

  task automatic gen_raw_stream();
    int n;
    n = $urandom_range(0, 24);
    push_header(FMT_RAW, n + (($urandom_range(0, 4) == 0) ? 1 : 0));
    repeat (n) push_byte(8'($urandom));
    push_byte(8'($urandom), 1'b1);
  endtask

  task automatic gen_noise();
    repeat ($urandom_range(1, 8))
      byte_stream.push_back('{1'($urandom_range(0, 1)), 8'($urandom),
                              1'($urandom_range(0, 9) == 0)});
  endtask

  task automatic gen_random_items(input int count);
    int start;
    start = byte_stream.size();
    while (byte_stream.size() - start < count) begin
      case ($urandom_range(0, 19))
        0, 1, 2: gen_raw_stream();
        3, 4, 5: gen_noise();
        default: gen_token_stream();
      endcase
    end
  endtask

  // sender: bursts of random length, random gaps, some long gap-free runs
  task automatic send_all();
    in_item_t it;
    int       burst;
    burst = $urandom_range(1, 40);
    while (byte_stream.size() > 0) begin
      if (burst == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
        burst = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
      end
      it = byte_stream.pop_front();
      s_axis_tvalid <= 1'b1;
      s_axis_tuser  <= it.tick;
      s_axis_tdata  <= it.data;
      s_axis_tlast  <= it.last;
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
      bytes_sent++;
      @(negedge clk_i);
      burst--;
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // capacity is only changed once the block has drained and settled
  task automatic write_capacity(input logic [31:0] cap);
    while (results_due != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // receiver: random stalls, calm stretches, and a forced long hold-off
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off) m_axis_tready <= 1'b0;
      else if ((bytes_sent / 97) % 3 == 0) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    hold_off = 1'b0;
    wait (bytes_sent > 600);
    @(negedge clk_i);
    hold_off = 1'b1;
    repeat (300) @(negedge clk_i);
    hold_off = 1'b0;
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [31:0] cap_steps [5];
    cap_steps     = '{32'd0, 32'd40, 32'd200, 32'hFFFF_FFFF, 32'd0};
    cap_steps[4]  = $urandom_range(10, 120);
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    bytes_sent    = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: idle tick, short header, zero length, unknown format,
    // raw pass-through, extended literal run with an overlapping copy
    byte_stream.push_back('{1'b1, 8'hFF, 1'b1});
    push_byte(FMT_TOKEN);
    push_byte(8'h05, 1'b1);
    push_header(FMT_TOKEN, 0);
    push_byte(8'hFF, 1'b1);
    push_header(8'h07, 1);
    push_byte(8'h00, 1'b1);
    push_header(FMT_RAW, 2);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'h5A, 1'b1);
    push_header(FMT_TOKEN, 18);
    push_byte(8'hF0);
    push_byte(8'h00);
    for (int i = 0; i < 15; i++) push_byte(8'(i * 17));
    push_byte(8'h01);
    push_byte(8'h00);
    push_ticks(3);
    push_byte(8'h00, 1'b1);
    send_all();

    foreach (cap_steps[k]) begin
      write_capacity(cap_steps[k]);
      gen_random_items(340);
      send_all();
    end

    while (results_due != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    $display("sent %0d transfers over six capacity settings, %0d results checked",
             bytes_sent, results_seen);
    $display("%0d streams ended, %0d match copy bytes", streams_ended, copies_seen);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/lzd_pkg.sv
hdl/lzd_ram.sv
hdl/lzd_decoder.sv
hdl/lz_token_stream_decompressor_unit.sv
hdl/lzd_checker.sv
tb/sv/lzd_stream_checker.sv
tb/sv/lz_token_stream_decompressor_unit_tb.sv
